### src/vgts_pkg.sv
// Shared types and constants for the voxel grid trilinear sampler.
`timescale 1ns / 1ps
`default_nettype none
package vgts_pkg;

  // Command codes carried by an input word.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  // Fixed field widths of the interface.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned VIDX_W     = 12;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned POS_FRAC_W = 16;

  // Size register reset value.
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 5'd16;

endpackage
`default_nettype wire

### src/vgts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module vgts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### src/voxel_grid_trilinear_sampler_core.sv
// Top level of the voxel grid trilinear sampler: pipeline, storage and configuration.
// Queries give a result through stages 1 to 6 and the output register; writes give none.
// Throughput: one word per cycle unless a held result stalls; the eight neighbors are read
// from eight copies of the voxel store, each with one read port; every write updates all copies.
// A stalled result stops the whole pipeline: in_stall is out_valid and out_stall together.
// Reset clears valid bits and sets the sizes to 16; voxel contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module voxel_grid_trilinear_sampler_core #(
  parameter int MAX_DIM    = 16,
  parameter int MAX_VOXELS = 4096,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_command,
  input  wire logic [vgts_pkg::VIDX_W-1:0]          in_voxel_index,
  input  wire logic [vgts_pkg::VAL_W-1:0]           in_voxel_value,
  input  wire logic [vgts_pkg::POS_W-1:0]           in_pos_x,
  input  wire logic [vgts_pkg::POS_W-1:0]           in_pos_y,
  input  wire logic [vgts_pkg::POS_W-1:0]           in_pos_z,
  // Result channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [vgts_pkg::VAL_W-1:0]           out_density,
  // Configuration channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [vgts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [vgts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SW   = $clog2(MAX_DIM + 1);
  localparam int CW   = SW + 2;
  localparam int UW   = vgts_pkg::POS_W + SW + 1;
  localparam int AW   = $clog2(MAX_VOXELS);
  localparam int LWA  = 3 * SW + 4;
  localparam int LW   = (LWA > AW + 2) ? LWA : AW + 2;
  localparam int VW   = 20;
  localparam int FB   = FRAC_BITS;
  localparam int VALW = vgts_pkg::VAL_W;
  localparam int PFW  = vgts_pkg::POS_FRAC_W;

  // Blend of two values with weight t in FB fraction bits, truncated.
  function automatic logic [VALW-1:0] blend(input logic [VALW-1:0] a,
                                            input logic [VALW-1:0] b,
                                            input logic [FB-1:0]   t);
    logic [FB:0]          wa;
    logic [VALW+FB:0]     pa;
    logic [VALW+FB:0]     pb;
    logic [VALW+FB:0]     acc;
    wa  = {1'b1, {FB{1'b0}}} - {1'b0, t};
    pa  = (VALW + FB + 1)'(a) * (VALW + FB + 1)'(wa);
    pb  = (VALW + FB + 1)'(b) * (VALW + FB + 1)'(t);
    acc = pa + pb;
    return acc[VALW+FB-1:FB];
  endfunction

  // Saturate a configured size to MAX_DIM.
  function automatic logic [SW-1:0] sat_size(input logic [vgts_pkg::CFG_DATA_W-1:0] s);
    logic [7:0] w;
    w = 8'(s);
    if (w > 8'(MAX_DIM)) begin
      w = 8'(MAX_DIM);
    end
    return w[SW-1:0];
  endfunction

  // Configuration registers.
  logic [vgts_pkg::CFG_DATA_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [SW-1:0]                   sx, sy, sz;
  logic [2*SW-1:0]                 sxy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= vgts_pkg::SIZE_RESET;
      size_y_r <= vgts_pkg::SIZE_RESET;
      size_z_r <= vgts_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vgts_pkg::REG_SIZE_X: size_x_r <= cfg_data;
        vgts_pkg::REG_SIZE_Y: size_y_r <= cfg_data;
        vgts_pkg::REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sx = sat_size(size_x_r);
  assign sy = sat_size(size_y_r);
  assign sz = sat_size(size_z_r);

  // Plane size, registered so it does not chain into the index multipliers.
  always_ff @(posedge clk) begin
    sxy_r <= (2 * SW)'(sx) * (2 * SW)'(sy);
  end

  // Global advance: the pipeline moves unless a finished word is held.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: input word.
  logic                      p1_v_r;
  logic                      p1_cmd_r;
  logic [vgts_pkg::VIDX_W-1:0] p1_idx_r;
  logic [VALW-1:0]           p1_val_r;
  logic [vgts_pkg::POS_W-1:0] p1_px_r, p1_py_r, p1_pz_r;

  // Stage 2: cells and weights.
  logic                      p2_v_r;
  logic                      p2_cmd_r;
  logic [vgts_pkg::VIDX_W-1:0] p2_idx_r;
  logic [VALW-1:0]           p2_val_r;
  logic signed [CW-1:0]      p2_cx_r, p2_cy_r, p2_cz_r;
  logic [FB-1:0]             p2_tx_r, p2_ty_r, p2_tz_r;

  // Stage 3: partial linear indexes and axis bounds.
  logic                      p3_v_r;
  logic                      p3_cmd_r;
  logic [vgts_pkg::VIDX_W-1:0] p3_idx_r;
  logic [VALW-1:0]           p3_val_r;
  logic signed [LW-1:0]      p3_xp_r, p3_yp_r, p3_zp_r;
  logic [1:0]                p3_okx_r, p3_oky_r, p3_okz_r;
  logic [FB-1:0]             p3_tx_r, p3_ty_r, p3_tz_r;

  // Stage 4: neighbor data from the stores.
  logic                      p4_v_r;
  logic [7:0]                p4_ok_r;
  logic [FB-1:0]             p4_tx_r, p4_ty_r, p4_tz_r;

  // Stage 5 and 6: x and y blends.
  logic                      p5_v_r;
  logic [VALW-1:0]           p5_x_r [4];
  logic [FB-1:0]             p5_ty_r, p5_tz_r;
  logic                      p6_v_r;
  logic [VALW-1:0]           p6_y0_r, p6_y1_r;
  logic [FB-1:0]             p6_tz_r;

  // Output register.
  logic                      out_valid_r;
  logic [VALW-1:0]           out_density_r;

  // Stage 1 to 2: scale by size, offset by half a voxel, split cell and fraction.
  logic [UW-1:0]             ux, uy, uz;
  logic [PFW+FB-1:0]         fx_w, fy_w, fz_w;
  logic signed [CW-1:0]      cx_nxt, cy_nxt, cz_nxt;

  always_comb begin
    ux     = UW'(p1_px_r) * UW'(sx) + UW'(1 << (PFW - 1));
    uy     = UW'(p1_py_r) * UW'(sy) + UW'(1 << (PFW - 1));
    uz     = UW'(p1_pz_r) * UW'(sz) + UW'(1 << (PFW - 1));
    cx_nxt = $signed(CW'(ux[UW-1:PFW])) - CW'(1);
    cy_nxt = $signed(CW'(uy[UW-1:PFW])) - CW'(1);
    cz_nxt = $signed(CW'(uz[UW-1:PFW])) - CW'(1);
    fx_w   = {ux[PFW-1:0], {FB{1'b0}}};
    fy_w   = {uy[PFW-1:0], {FB{1'b0}}};
    fz_w   = {uz[PFW-1:0], {FB{1'b0}}};
  end

  // Stage 2 to 3: row and plane offsets, bounds of both neighbors per axis.
  logic signed [LW-1:0]      cxl, cyl, czl, sxl, sxyl;
  logic signed [CW-1:0]      cx1, cy1, cz1, sxc, syc, szc;
  logic signed [LW-1:0]      yp_nxt, zp_nxt;
  logic [1:0]                okx_nxt, oky_nxt, okz_nxt;

  always_comb begin
    cxl     = LW'(p2_cx_r);
    cyl     = LW'(p2_cy_r);
    czl     = LW'(p2_cz_r);
    sxl     = LW'(sx);
    sxyl    = LW'(sxy_r);
    yp_nxt  = LW'(cyl * sxl);
    zp_nxt  = LW'(czl * sxyl);
    sxc     = CW'(sx);
    syc     = CW'(sy);
    szc     = CW'(sz);
    cx1     = p2_cx_r + CW'(1);
    cy1     = p2_cy_r + CW'(1);
    cz1     = p2_cz_r + CW'(1);
    okx_nxt = {(cx1 < sxc), (p2_cx_r >= 0) && (p2_cx_r < sxc)};
    oky_nxt = {(cy1 < syc), (p2_cy_r >= 0) && (p2_cy_r < syc)};
    okz_nxt = {(cz1 < szc), (p2_cz_r >= 0) && (p2_cz_r < szc)};
  end

  // Stage 3: neighbor addresses, in-grid flags and the voxel write.
  logic signed [LW-1:0]      nb_idx [8];
  logic [AW-1:0]             nb_addr [8];
  logic [7:0]                nb_ok;
  logic [VW-1:0]             widx;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      nb_idx[n] = p3_zp_r + (n[2] ? LW'(sxy_r) : LW'(0))
                + p3_yp_r + (n[1] ? LW'(sx) : LW'(0))
                + p3_xp_r + LW'(n[0]);
      nb_addr[n] = nb_idx[n][AW-1:0];
      nb_ok[n]   = p3_okx_r[n[0]] && p3_oky_r[n[1]] && p3_okz_r[n[2]]
                && (nb_idx[n] < LW'(MAX_VOXELS));
    end
    widx      = VW'(p3_idx_r);
    ram_waddr = widx[AW-1:0];
    ram_we    = adv && p3_v_r && (p3_cmd_r == vgts_pkg::CMD_WRITE)
             && (widx < VW'(MAX_VOXELS));
  end

  // One store copy per neighbor corner, all written alike.
  logic [VALW-1:0]           rd [8];

  for (genvar g = 0; g < 8; g++) begin : g_store
    vgts_ram #(
      .WIDTH (VALW),
      .DEPTH (MAX_VOXELS)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (p3_val_r),
      .rd_en   (adv),
      .rd_addr (nb_addr[g]),
      .rd_data (rd[g])
    );
  end

  // Stage 4 to 5: zero the corners outside the grid, blend along x.
  logic [VALW-1:0]           cm [8];
  logic [VALW-1:0]           x_nxt [4];

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      cm[n] = p4_ok_r[n] ? rd[n] : '0;
    end
    for (int k = 0; k < 4; k++) begin
      x_nxt[k] = blend(cm[2*k], cm[2*k+1], p4_tx_r);
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      p4_v_r      <= 1'b0;
      p5_v_r      <= 1'b0;
      p6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p1_v_r      <= in_valid;
      p2_v_r      <= p1_v_r;
      p3_v_r      <= p2_v_r;
      p4_v_r      <= p3_v_r && (p3_cmd_r == vgts_pkg::CMD_QUERY);
      p5_v_r      <= p4_v_r;
      p6_v_r      <= p5_v_r;
      out_valid_r <= p6_v_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_cmd_r <= in_command;
      p1_idx_r <= in_voxel_index;
      p1_val_r <= in_voxel_value;
      p1_px_r  <= in_pos_x;
      p1_py_r  <= in_pos_y;
      p1_pz_r  <= in_pos_z;

      p2_cmd_r <= p1_cmd_r;
      p2_idx_r <= p1_idx_r;
      p2_val_r <= p1_val_r;
      p2_cx_r  <= cx_nxt;
      p2_cy_r  <= cy_nxt;
      p2_cz_r  <= cz_nxt;
      p2_tx_r  <= fx_w[PFW+FB-1:PFW];
      p2_ty_r  <= fy_w[PFW+FB-1:PFW];
      p2_tz_r  <= fz_w[PFW+FB-1:PFW];

      p3_cmd_r <= p2_cmd_r;
      p3_idx_r <= p2_idx_r;
      p3_val_r <= p2_val_r;
      p3_xp_r  <= cxl;
      p3_yp_r  <= yp_nxt;
      p3_zp_r  <= zp_nxt;
      p3_okx_r <= okx_nxt;
      p3_oky_r <= oky_nxt;
      p3_okz_r <= okz_nxt;
      p3_tx_r  <= p2_tx_r;
      p3_ty_r  <= p2_ty_r;
      p3_tz_r  <= p2_tz_r;

      p4_ok_r  <= nb_ok;
      p4_tx_r  <= p3_tx_r;
      p4_ty_r  <= p3_ty_r;
      p4_tz_r  <= p3_tz_r;

      p5_x_r   <= x_nxt;
      p5_ty_r  <= p4_ty_r;
      p5_tz_r  <= p4_tz_r;

      p6_y0_r  <= blend(p5_x_r[0], p5_x_r[1], p5_ty_r);
      p6_y1_r  <= blend(p5_x_r[2], p5_x_r[3], p5_ty_r);
      p6_tz_r  <= p5_tz_r;

      out_density_r <= blend(p6_y0_r, p6_y1_r, p6_tz_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_density = out_density_r;

`ifndef ASSERT_OFF
  // The stores are written only while the pipeline moves.
  a_we_adv: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> adv)
    else $error("voxel write while the pipeline is held");

  // A held pipeline keeps the word that waits on the store data.
  a_hold_p4: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(p4_v_r) && $stable(p4_ok_r))
    else $error("stage 4 changed during a stall");

  // A new result appears only after an advance.
  a_rise_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("result appeared without an advance");

  // Only queries reach the blend stages.
  a_query_only: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && p3_v_r && p3_cmd_r == vgts_pkg::CMD_WRITE) |=> !p4_v_r)
    else $error("write word entered the blend stages");
`endif

endmodule
`default_nettype wire

### test/voxel_grid_trilinear_sampler_core_tb.sv
// Self-checking testbench for the voxel grid trilinear sampler core.
`timescale 1ns / 1ps
module voxel_grid_trilinear_sampler_core_tb;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int GRID_MAX     = 16;
  localparam int STORE_DEPTH  = 4096;
  localparam int PHASE_ITEMS  = 135;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 5000;

  typedef struct {
    vgts_pkg::cmd_t                cmd;
    logic [vgts_pkg::VIDX_W-1:0]   vidx;
    logic [vgts_pkg::VAL_W-1:0]    value;
    logic [vgts_pkg::POS_W-1:0]    px;
    logic [vgts_pkg::POS_W-1:0]    py;
    logic [vgts_pkg::POS_W-1:0]    pz;
  } sample_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [vgts_pkg::VIDX_W-1:0] in_voxel_index = '0;
  logic [vgts_pkg::VAL_W-1:0] in_voxel_value = '0;
  logic [vgts_pkg::POS_W-1:0] in_pos_x = '0;
  logic [vgts_pkg::POS_W-1:0] in_pos_y = '0;
  logic [vgts_pkg::POS_W-1:0] in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [vgts_pkg::VAL_W-1:0] out_density;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vgts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vgts_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Words waiting to be sent, densities waiting to come back.
  sample_word_t pending_words[$];
  logic [vgts_pkg::VAL_W-1:0] density_q[$];

  // Mirror of the block's storage and size registers.
  logic [vgts_pkg::VAL_W-1:0] voxel_mirror[STORE_DEPTH];
  bit written_map[STORE_DEPTH];
  logic [vgts_pkg::CFG_DATA_W-1:0] grid_x = vgts_pkg::SIZE_RESET;
  logic [vgts_pkg::CFG_DATA_W-1:0] grid_y = vgts_pkg::SIZE_RESET;
  logic [vgts_pkg::CFG_DATA_W-1:0] grid_z = vgts_pkg::SIZE_RESET;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int fail_count = 0;
  int query_count = 0;
  int write_count = 0;
  int density_count = 0;
  int quiet_cycles = 0;
  int phase_count = 0;

  voxel_grid_trilinear_sampler_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned axis_span(logic [vgts_pkg::CFG_DATA_W-1:0] s);
    return (s > GRID_MAX) ? GRID_MAX : s;
  endfunction

  // Scales a position to voxel-center space and splits it into voxel and weight.
  function automatic void split_axis(input longint unsigned pos, input longint unsigned n,
                                     output longint vox, output longint unsigned w);
    longint unsigned u;
    u = pos * n + 32768;
    vox = longint'(u >> 16) - 1;
    w = u & 16'hFFFF;
  endfunction

  // Linear index of a neighbor inside the grid, or -1 when it lies outside the grid or the store.
  function automatic longint grid_slot(longint x, longint y, longint z);
    longint unsigned sx, sy, sz, lin;
    sx = axis_span(grid_x);
    sy = axis_span(grid_y);
    sz = axis_span(grid_z);
    if (x < 0 || y < 0 || z < 0) return -1;
    if (x >= sx || y >= sy || z >= sz) return -1;
    lin = z * sx * sy + y * sx + x;
    if (lin >= STORE_DEPTH) return -1;
    return lin;
  endfunction

  function automatic longint unsigned lerp16(longint unsigned a, longint unsigned b,
                                             longint unsigned t);
    return (a * (65536 - t) + b * t) >> 16;
  endfunction

  // Expected density of a query, blending x first, then y, then z.
  function automatic logic [vgts_pkg::VAL_W-1:0] interp_density(
      logic [vgts_pkg::POS_W-1:0] px, logic [vgts_pkg::POS_W-1:0] py,
      logic [vgts_pkg::POS_W-1:0] pz);
    longint cx, cy, cz, slot;
    longint unsigned tx, ty, tz;
    longint unsigned c[8];
    longint unsigned x0[4];
    longint unsigned y0, y1;
    split_axis(px, axis_span(grid_x), cx, tx);
    split_axis(py, axis_span(grid_y), cy, ty);
    split_axis(pz, axis_span(grid_z), cz, tz);
    for (int k = 0; k < 8; k++) begin
      slot = grid_slot(cx + (k & 1), cy + ((k >> 1) & 1), cz + ((k >> 2) & 1));
      c[k] = (slot < 0) ? 0 : voxel_mirror[slot];
    end
    for (int k = 0; k < 4; k++) begin
      x0[k] = lerp16(c[2*k], c[2*k+1], tx);
    end
    y0 = lerp16(x0[0], x0[1], ty);
    y1 = lerp16(x0[2], x0[3], ty);
    return vgts_pkg::VAL_W'(lerp16(y0, y1, tz));
  endfunction

  task automatic add_write(logic [vgts_pkg::VIDX_W-1:0] vidx,
                           logic [vgts_pkg::VAL_W-1:0] value);
    sample_word_t w;
    w.cmd = vgts_pkg::CMD_WRITE;
    w.vidx = vidx;
    w.value = value;
    w.px = vgts_pkg::POS_W'($urandom);
    w.py = vgts_pkg::POS_W'($urandom);
    w.pz = vgts_pkg::POS_W'($urandom);
    written_map[vidx] = 1'b1;
    pending_words.push_back(w);
  endtask

  // Fills any unwritten in-grid neighbor first, so no query reads undefined storage.
  task automatic add_query(logic [vgts_pkg::POS_W-1:0] px, logic [vgts_pkg::POS_W-1:0] py,
                           logic [vgts_pkg::POS_W-1:0] pz);
    sample_word_t w;
    longint cx, cy, cz, slot;
    longint unsigned t;
    split_axis(px, axis_span(grid_x), cx, t);
    split_axis(py, axis_span(grid_y), cy, t);
    split_axis(pz, axis_span(grid_z), cz, t);
    for (int k = 0; k < 8; k++) begin
      slot = grid_slot(cx + (k & 1), cy + ((k >> 1) & 1), cz + ((k >> 2) & 1));
      if (slot >= 0 && !written_map[slot]) begin
        add_write(vgts_pkg::VIDX_W'(slot), vgts_pkg::VAL_W'($urandom));
      end
    end
    w.cmd = vgts_pkg::CMD_QUERY;
    w.vidx = vgts_pkg::VIDX_W'($urandom);
    w.value = vgts_pkg::VAL_W'($urandom);
    w.px = px;
    w.py = py;
    w.pz = pz;
    pending_words.push_back(w);
  endtask

  function automatic logic [vgts_pkg::POS_W-1:0] rand_pos();
    return ($urandom_range(0, 99) < 80) ? vgts_pkg::POS_W'($urandom_range(0, 65536))
                                        : vgts_pkg::POS_W'($urandom_range(0, 131071));
  endfunction

  // Writes the three size registers back to back, plus the unused index when asked.
  task automatic set_sizes(logic [vgts_pkg::CFG_DATA_W-1:0] sx,
                           logic [vgts_pkg::CFG_DATA_W-1:0] sy,
                           logic [vgts_pkg::CFG_DATA_W-1:0] sz, bit touch_unused);
    logic [vgts_pkg::CFG_IDX_W-1:0] idx_list[4];
    logic [vgts_pkg::CFG_DATA_W-1:0] val_list[4];
    int n;
    idx_list = '{vgts_pkg::REG_SIZE_X, vgts_pkg::REG_SIZE_Y, vgts_pkg::REG_SIZE_Z,
                 REG_UNUSED};
    val_list = '{sx, sy, sz, vgts_pkg::CFG_DATA_W'($urandom)};
    n = touch_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[k];
      cfg_data <= val_list[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx_list[k])
        vgts_pkg::REG_SIZE_X: grid_x = val_list[k];
        vgts_pkg::REG_SIZE_Y: grid_y = val_list[k];
        vgts_pkg::REG_SIZE_Z: grid_z = val_list[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every word is sent and every density has come back.
  task automatic wait_drained();
    do @(posedge clk); while (pending_words.size() != 0 || in_valid || density_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: next word goes out once the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        sample_word_t w;
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_command <= w.cmd;
        in_voxel_index <= w.vidx;
        in_voxel_value <= w.value;
        in_pos_x <= w.px;
        in_pos_y <= w.py;
        in_pos_z <= w.pz;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < receiver_stall_pct);
  end

  // Monitor: update the mirror on accepted words and check returned densities.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (vgts_pkg::cmd_t'(in_command) == vgts_pkg::CMD_WRITE) begin
          voxel_mirror[in_voxel_index] = in_voxel_value;
          write_count++;
        end else begin
          density_q.push_back(interp_density(in_pos_x, in_pos_y, in_pos_z));
          query_count++;
        end
      end
      if (out_valid && !out_stall) begin
        density_count++;
        if (density_q.size() == 0) begin
          $error("density: unexpected word, actual %0d", out_density);
          fail_count++;
        end else begin
          logic [vgts_pkg::VAL_W-1:0] want;
          want = density_q.pop_front();
          if (out_density !== want) begin
            $error("density mismatch: expected %0d, actual %0d", want, out_density);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("voxel_grid_trilinear_sampler_core_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [vgts_pkg::CFG_DATA_W-1:0] sizes[8][3];
    int start_len;
    sizes = '{'{5'd16, 5'd16, 5'd16}, '{5'd1, 5'd1, 5'd1}, '{5'd0, 5'd7, 5'd3},
              '{5'd31, 5'd17, 5'd16}, '{5'd5, 5'd3, 5'd9}, '{5'd2, 5'd16, 5'd1},
              '{5'd16, 5'd16, 5'd16}, '{5'd0, 5'd0, 5'd0}};
    for (int k = 0; k < 3; k++) begin
      sizes[7][k] = vgts_pkg::CFG_DATA_W'($urandom_range(0, 31));
    end
    for (int k = 0; k < STORE_DEPTH; k++) voxel_mirror[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      // Phase 0 runs on the reset sizes; later phases reprogram while idle.
      if (ph > 0) begin
        wait_drained();
        set_sizes(sizes[ph][0], sizes[ph][1], sizes[ph][2], ph == 6);
      end
      case (ph % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
      endcase
      phase_count++;
      start_len = write_count + query_count + pending_words.size();

      // Directed corners: extreme values, unit-cube edges, above-one positions.
      if (ph == 0) begin
        add_write(12'd0, 16'hFFFF);
        add_write(12'd4095, 16'h0000);
        add_write(12'd1, 16'h0000);
        add_write(12'd16, 16'hFFFF);
        add_query(17'd0, 17'd0, 17'd0);
        add_query(17'd65536, 17'd65536, 17'd65536);
        add_query(17'd32768, 17'd32768, 17'd32768);
        add_query(17'd2048, 17'd2048, 17'd2048);
        add_query(17'd131071, 17'd131071, 17'd131071);
        add_query(17'd6144, 17'd65535, 17'd1);
        add_query(17'd70000, 17'd0, 17'd65536);
      end

      while (write_count + query_count + pending_words.size() - start_len < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 25) begin
          add_write(vgts_pkg::VIDX_W'($urandom), vgts_pkg::VAL_W'($urandom));
        end else begin
          add_query(rand_pos(), rand_pos(), rand_pos());
        end
      end
    end
    wait_drained();

    $display("covered %0d phases of grid sizes, %0d voxel writes, %0d queries",
             phase_count, write_count, query_count);
    $display("checked %0d densities with %0d mismatches", density_count, fail_count);
    if (fail_count == 0 && density_q.size() == 0) begin
      $display("voxel_grid_trilinear_sampler_core_tb: PASS");
    end else begin
      $display("voxel_grid_trilinear_sampler_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
src/vgts_pkg.sv
src/vgts_ram.sv
src/voxel_grid_trilinear_sampler_core.sv
test/voxel_grid_trilinear_sampler_core_tb.sv
